// ===== hdl/cdr_pkg.sv =====
// Shared constants and types of the aligned primitive pack and unpack block.
package cdr_pkg;

   // Default buffer size in bytes.
   localparam int BUF_BYTES_DEF = 1024;

   // Width of the level fields on the result channel.
   localparam int LEVEL_W = 11;

   // Operation codes on req_func.
   localparam logic [1:0] FUNC_PUT    = 2'd0;
   localparam logic [1:0] FUNC_GET    = 2'd1;
   localparam logic [1:0] FUNC_REWIND = 2'd2;

   // Status codes on rsp_status.
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NO_SPACE = 2'd1;
   localparam logic [1:0] STAT_NO_DATA  = 2'd2;

   // Register index of the byte order register (taken from paddr[2]).
   localparam logic CSR_BIG_ENDIAN = 1'b0;

   // Work handed from the pointer stage to the memory and byte lane stage.
   typedef struct packed {
      logic       wr;          // put that stores its value
      logic       rd;          // get that returns a value
      logic [2:0] offset;      // byte offset of the access inside its word
      logic [1:0] size_code;   // log2 of the access size in bytes
      logic       big_endian;  // wire byte order for this access
      logic [1:0] status;      // status of the item
   } exec_type;

endpackage

// ===== hdl/cdr_mem.sv =====
// Word memory of the byte buffer with one write port and a registered read port.
module cdr_mem
   import cdr_pkg::*;
#(
   parameter int DEPTH = (BUF_BYTES_DEF + 7) / 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [63:0]   wr_data,
   output logic [63:0]   rd_data
);

   logic [63:0] store_ff [DEPTH];
   logic [63:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/cdr_ctrl.sv =====
// Pointer stage: alignment, space and data checks, pointer update and sequencing.
module cdr_ctrl
   import cdr_pkg::*;
#(
   parameter int BUF_BYTES = BUF_BYTES_DEF,
   localparam int PTR_W = $clog2(BUF_BYTES + 1),
   localparam int WORDS = (BUF_BYTES + 7) / 8,
   localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [1:0]       func,
   input  logic [1:0]       size_code,
   input  logic [63:0]      put_value,
   input  logic             big_endian,
   output logic             busy,
   output logic             rd_en,
   output logic [AW-1:0]    rd_addr,
   output logic             wr_en,
   output logic [AW-1:0]    wr_addr,
   output exec_type         exec,
   output logic [63:0]      exec_value,
   output logic [PTR_W-1:0] write_ptr,
   output logic [PTR_W-1:0] read_ptr
);

   // One extra bit holds an aligned position or an end past the buffer.
   localparam int SW = PTR_W + 1;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   exec_type         exec_ff, exec_in;
   logic [AW-1:0]    addr_ff;
   logic [63:0]      value_ff;

   logic          accept;
   logic [SW-1:0] n_sum, mask, lim, wp_x, rp_x;
   logic [SW-1:0] w_al, r_al, w_end, r_end, pos;
   logic          wr_ok, get_ok;
   logic [1:0]    status;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff == S_EXEC);

   // Aligned positions for both pointers, relative to the buffer start.
   assign n_sum = SW'(1) << size_code;
   assign mask  = n_sum - SW'(1);
   assign lim   = SW'(BUF_BYTES);
   assign wp_x  = SW'(wp_ff);
   assign rp_x  = SW'(rp_ff);
   assign w_al  = (wp_x + mask) & ~mask;
   assign r_al  = (rp_x + mask) & ~mask;
   assign w_end = w_al + n_sum;
   assign r_end = r_al + n_sum;

   // Decide the outcome of the item and the new pointers.
   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      status = STAT_OK;
      wr_ok  = 1'b0;
      get_ok = 1'b0;
      pos    = w_al;
      if (accept) begin
         unique case (func)
            FUNC_PUT: begin
               if (w_al > lim) begin
                  status = STAT_NO_SPACE;
               end else if (w_end > lim) begin
                  status = STAT_NO_SPACE;
                  wp_in  = PTR_W'(w_al);
               end else begin
                  wp_in = PTR_W'(w_end);
                  wr_ok = 1'b1;
               end
            end
            FUNC_GET: begin
               pos = r_al;
               if (r_al > wp_x) begin
                  status = STAT_NO_DATA;
               end else if (r_end > wp_x) begin
                  status = STAT_NO_DATA;
                  rp_in  = PTR_W'(r_al);
               end else begin
                  rp_in  = PTR_W'(r_end);
                  get_ok = 1'b1;
               end
            end
            FUNC_REWIND: begin
               wp_in = '0;
               rp_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // An aligned access never crosses a word, so one word read covers it.
   assign rd_en   = wr_ok || get_ok;
   assign rd_addr = pos[AW+2:3];

   always_comb begin
      exec_in.wr         = wr_ok;
      exec_in.rd         = get_ok;
      exec_in.offset     = pos[2:0];
      exec_in.size_code  = size_code;
      exec_in.big_endian = big_endian;
      exec_in.status     = status;
   end

   // Every accepted item passes through the execute state while its word comes back.
   assign state_in = accept ? S_EXEC : S_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wp_ff    <= '0;
         rp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
      end
   end

   // Item payload held for the execute cycle.
   always_ff @(posedge clock) begin
      if (accept) begin
         exec_ff  <= exec_in;
         addr_ff  <= rd_addr;
         value_ff <= put_value;
      end
   end

   // The merged word is written back at the end of the execute cycle.
   assign wr_en      = busy && exec_ff.wr;
   assign wr_addr    = addr_ff;
   assign exec       = exec_ff;
   assign exec_value = value_ff;
   assign write_ptr  = wp_ff;
   assign read_ptr   = rp_ff;

endmodule

// ===== hdl/cdr_lane.sv =====
// Byte lanes: merges a put value into its word and extracts a get value from it.
module cdr_lane
   import cdr_pkg::*;
(
   input  exec_type    exec,
   input  logic [63:0] rd_word,
   input  logic [63:0] put_value,
   output logic [63:0] wr_word,
   output logic [63:0] got_value
);

   logic [3:0] n4;
   assign n4 = 4'd1 << exec.size_code;

   // Bytes below the access stay, the access takes the value and the bytes
   // above it are cleared, so later padding bytes in this word read as zero.
   always_comb begin
      logic [3:0] rel;
      logic [2:0] k;
      wr_word = '0;
      rel     = '0;
      k       = '0;
      for (int b = 0; b < 8; b++) begin
         rel = 4'(b) - {1'b0, exec.offset};
         if (4'(b) < {1'b0, exec.offset}) begin
            wr_word[b*8 +: 8] = rd_word[b*8 +: 8];
         end else if (rel < n4) begin
            k = exec.big_endian ? 3'(n4 - 4'd1 - rel) : rel[2:0];
            wr_word[b*8 +: 8] = put_value[{k, 3'b000} +: 8];
         end else begin
            wr_word[b*8 +: 8] = 8'h00;
         end
      end
   end

   // Gather the bytes of a get into a zero-extended value.
   always_comb begin
      logic [2:0] src;
      logic [2:0] k;
      got_value = '0;
      src       = '0;
      k         = '0;
      if (exec.rd) begin
         for (int i = 0; i < 8; i++) begin
            if (4'(i) < n4) begin
               src = exec.offset + 3'(i);
               k   = exec.big_endian ? 3'(n4 - 4'd1 - 4'(i)) : 3'(i);
               got_value[{k, 3'b000} +: 8] = rd_word[{src, 3'b000} +: 8];
            end
         end
      end
   end

endmodule

// ===== hdl/cdr_primitive_pack_unpack.sv =====
// Top level of the aligned primitive pack and unpack block.
//
// Commands enter on start with req_func, req_size_code and req_put_value and
// are taken at a rising edge where start is high and busy is low. A put pads
// the write pointer to the access size and stores the value, a get aligns the
// read pointer and returns the value, a rewind clears both pointers.
// Each command has an accept cycle, which issues the buffer word read of a put or
// get that succeeds, and a following execute cycle (busy high), which merges or
// extracts bytes and writes a put's word back; no command is taken while busy.
// The result word appears in the cycle after the execute cycle, with rsp_valid
// high for exactly one cycle; the receiver cannot stall it and must take it.
// The APB port holds the byte order register at address 0; pready is always
// high. Write it only while no command is in flight.
// Reset clears both pointers and the byte order register; the buffer memory
// is not cleared, since a get only reads bytes written since the last rewind.
module cdr_primitive_pack_unpack
   import cdr_pkg::*;
#(
   parameter int BUF_BYTES = BUF_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_func,
   input  logic [1:0]          req_size_code,
   input  logic [63:0]         req_put_value,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [63:0]         rsp_got_value,
   output logic [LEVEL_W-1:0]  rsp_write_level,
   output logic [LEVEL_W-1:0]  rsp_read_level,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam int PTR_W = $clog2(BUF_BYTES + 1);
   localparam int WORDS = (BUF_BYTES + 7) / 8;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int EXT_W = (PTR_W > LEVEL_W) ? PTR_W : LEVEL_W;

   logic             big_endian_ff;
   logic             rd_en, wr_en;
   logic [AW-1:0]    rd_addr, wr_addr;
   logic [63:0]      rd_word, wr_word, got_value, exec_value;
   exec_type         exec;
   logic [PTR_W-1:0] write_ptr, read_ptr;
   logic [EXT_W-1:0] wp_ext, rp_ext;

   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff;
   logic [63:0]         rsp_got_value_ff;
   logic [LEVEL_W-1:0]  rsp_write_level_ff;
   logic [LEVEL_W-1:0]  rsp_read_level_ff;

   // Configuration register: byte order.
   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff <= 1'b0;
      end else if (psel && penable && pwrite && pready && (paddr[2] == CSR_BIG_ENDIAN)) begin
         big_endian_ff <= pwdata[0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_BIG_ENDIAN) ? {31'd0, big_endian_ff} : 32'd0;

   cdr_ctrl #(
      .BUF_BYTES (BUF_BYTES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .func       (req_func),
      .size_code  (req_size_code),
      .put_value  (req_put_value),
      .big_endian (big_endian_ff),
      .busy       (busy),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .exec       (exec),
      .exec_value (exec_value),
      .write_ptr  (write_ptr),
      .read_ptr   (read_ptr)
   );

   cdr_mem #(
      .DEPTH (WORDS)
   ) u_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_data (rd_word)
   );

   cdr_lane u_lane (
      .exec      (exec),
      .rd_word   (rd_word),
      .put_value (exec_value),
      .wr_word   (wr_word),
      .got_value (got_value)
   );

   // Levels are the pointers cut or extended to the field width.
   assign wp_ext = EXT_W'(write_ptr);
   assign rp_ext = EXT_W'(read_ptr);

   // Result register, loaded at the end of the execute cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= busy;
      end
   end

   always_ff @(posedge clock) begin
      if (busy) begin
         rsp_status_ff      <= exec.status;
         rsp_got_value_ff   <= got_value;
         rsp_write_level_ff <= wp_ext[LEVEL_W-1:0];
         rsp_read_level_ff  <= rp_ext[LEVEL_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_got_value   = rsp_got_value_ff;
   assign rsp_write_level = rsp_write_level_ff;
   assign rsp_read_level  = rsp_read_level_ff;

endmodule

// ===== hdl/cdr_checker.sv =====
// Port level checks of the pack and unpack block, bound to its top level.
module cdr_checker
   import cdr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [63:0] rsp_got_value
);

   // An accepted word always enters the execute cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not enter the execute cycle");

   // The execute cycle lasts exactly one cycle.
   a_busy_one: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held longer than one cycle");

   // Every execute cycle is followed by a result word.
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid)
      else $error("execute cycle without a result word");

   // A failed access returns a zero value.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_OK) |-> (rsp_got_value == 64'd0))
      else $error("failed access returned a nonzero value");

endmodule

bind cdr_primitive_pack_unpack cdr_checker u_checker (.*);
